// File: sv/b92_pkg.sv
package b92_pkg;

  // one message byte and its framing flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_message;
  } in_word_t;

  // one encoded character
  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_word_t;

  typedef enum logic [1:0] {
    FL_NONE,
    FL_SHORT,
    FL_LONG
  } flush_kind_t;

  // raw bit groups cut from one byte, before the divide and the table
  typedef struct packed {
    logic        empty;
    logic        last_byte;
    logic        c0_valid;
    logic [12:0] c0;
    flush_kind_t fl_kind;
    logic [12:0] fl_val;
  } group_t;

  localparam int unsigned MaxChars = 4;

  // up to four characters handed to the output sequencer at once
  typedef struct packed {
    logic [2:0]                   n;
    out_word_t [MaxChars-1:0]     ents;
  } seq_load_t;

  localparam logic [6:0]  CH_BANG   = 7'd33;
  localparam logic [6:0]  CH_TILDE  = 7'd126;
  localparam logic [6:0]  RADIX     = 7'd91;
  localparam logic [4:0]  CHUNK_LEN = 5'd13;
  localparam logic [3:0]  SHORT_LEN = 4'd6;
  // ceil(2^20 / 91), exact quotient for every 13-bit chunk
  localparam logic [13:0] RECIP91   = 14'd11523;
  localparam int unsigned RecipShift = 20;

  // index 0..90 to printable ascii, skipping the double quote and the backquote
  function automatic logic [6:0] map_index(input logic [6:0] v);
    logic [6:0] res;
    if (v == 7'd0) begin
      res = CH_BANG;
    end else if (v <= 7'd61) begin
      res = v + 7'd34;
    end else begin
      res = v + 7'd35;
    end
    return res;
  endfunction

endpackage

// File: sv/b92_div91.sv
module b92_div91 (
  input  logic [12:0] chunk,
  output logic [6:0]  quo,
  output logic [6:0]  rem
);
  import b92_pkg::*;

  logic [26:0] prod;
  logic [12:0] back;

  // reciprocal multiply, then take the remainder back out
  assign prod = 27'(chunk) * 27'(RECIP91);
  assign quo  = prod[RecipShift +: 7];
  assign back = 13'(quo) * 13'(RADIX);
  assign rem  = 7'(chunk - back);
endmodule

// File: sv/b92_chars.sv
module b92_chars (
  input  b92_pkg::group_t   grp,
  output b92_pkg::seq_load_t ld
);
  import b92_pkg::*;

  logic [6:0] q0;
  logic [6:0] r0;
  logic [6:0] q1;
  logic [6:0] r1;

  b92_div91 u_div_chunk (
    .chunk (grp.c0),
    .quo   (q0),
    .rem   (r0)
  );

  b92_div91 u_div_flush (
    .chunk (grp.fl_val),
    .quo   (q1),
    .rem   (r1)
  );

  always_comb begin
    logic [1:0] base;
    base = 2'd0;
    ld   = '0;
    if (grp.empty) begin
      ld.ents[0].out_char  = CH_TILDE;
      ld.ents[0].last_char = 1'b1;
      ld.n = 3'd1;
    end else begin
      if (grp.c0_valid) begin
        ld.ents[0].out_char  = map_index(q0);
        ld.ents[0].last_char = 1'b0;
        ld.ents[1].out_char  = map_index(r0);
        // final byte that leaves nothing to flush closes on this character
        ld.ents[1].last_char = grp.last_byte && (grp.fl_kind == FL_NONE);
        base = 2'd2;
      end
      unique case (grp.fl_kind)
        FL_NONE: begin
          ld.n = {1'b0, base};
        end
        FL_SHORT: begin
          ld.ents[base].out_char  = map_index({1'b0, grp.fl_val[5:0]});
          ld.ents[base].last_char = 1'b1;
          ld.n = {1'b0, base} + 3'd1;
        end
        FL_LONG: begin
          ld.ents[base].out_char          = map_index(q1);
          ld.ents[base].last_char         = 1'b0;
          ld.ents[base + 2'd1].out_char   = map_index(r1);
          ld.ents[base + 2'd1].last_char  = 1'b1;
          ld.n = {1'b0, base} + 3'd2;
        end
        default: begin
          ld.n = {1'b0, base};
        end
      endcase
    end
  end
endmodule

// File: sv/b92_pack.sv
module b92_pack (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  b92_pkg::in_word_t word,
  output b92_pkg::group_t  grp_next
);
  import b92_pkg::*;

  logic [11:0] pend_bits;
  logic [3:0]  pend_cnt;
  logic [11:0] pend_bits_next;
  logic [3:0]  pend_cnt_next;

  logic [19:0] acc;
  logic [4:0]  cnt_all;
  logic [4:0]  cnt_sub;
  logic        hit;
  logic [3:0]  cnt_left;
  logic [11:0] left_bits;
  logic [2:0]  sh_short;
  logic [3:0]  sh_long;

  assign acc      = {pend_bits, word.data_byte};
  assign cnt_all  = {1'b0, pend_cnt} + 5'd8;
  assign cnt_sub  = cnt_all - CHUNK_LEN;
  assign hit      = cnt_all >= CHUNK_LEN;
  assign cnt_left = hit ? cnt_sub[3:0] : cnt_all[3:0];
  assign left_bits = acc[11:0] & ~(12'hFFF << cnt_left);
  assign sh_short = 3'(SHORT_LEN - cnt_left);
  assign sh_long  = 4'(CHUNK_LEN[3:0] - cnt_left);

  always_comb begin
    grp_next.empty     = word.empty_message;
    grp_next.last_byte = word.last_byte;
    grp_next.c0_valid  = hit && !word.empty_message;
    grp_next.c0        = 13'(acc >> cnt_sub[2:0]);
    grp_next.fl_kind   = FL_NONE;
    grp_next.fl_val    = '0;
    if (word.last_byte && !word.empty_message && cnt_left != 4'd0) begin
      // leftover bits padded on the right
      if (cnt_left < 4'd7) begin
        grp_next.fl_kind = FL_SHORT;
        grp_next.fl_val  = {7'd0, 6'(left_bits << sh_short)};
      end else begin
        grp_next.fl_kind = FL_LONG;
        grp_next.fl_val  = 13'(left_bits) << sh_long;
      end
    end
  end

  always_comb begin
    if (word.empty_message || word.last_byte) begin
      pend_bits_next = '0;
      pend_cnt_next  = '0;
    end else begin
      pend_bits_next = left_bits;
      pend_cnt_next  = cnt_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else if (accept) begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end
endmodule

// File: sv/b92_out_seq.sv
module b92_out_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  b92_pkg::seq_load_t  ld,
  output logic                can_load,
  output logic                enc_valid,
  input  logic                enc_stall,
  output b92_pkg::out_word_t  enc
);
  import b92_pkg::*;

  out_word_t [MaxChars-1:0] ents;
  logic [2:0] cnt;
  logic [1:0] rd;
  logic       pop;

  assign enc_valid = cnt != 3'd0;
  assign enc       = ents[rd];
  assign pop       = enc_valid && !enc_stall;
  // refill as the last held word leaves
  assign can_load  = (cnt == 3'd0) || (cnt == 3'd1 && pop);

  always_ff @(posedge clk) begin
    if (load) begin
      ents <= ld.ents;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= '0;
    end else if (load) begin
      cnt <= ld.n;
      rd  <= '0;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
      rd  <= rd + 2'd1;
    end
  end
endmodule

// File: sv/base92_byte_encoder.sv
// Streaming base92 encoder. Each msg word carries one byte plus last/empty
// flags; each enc word is one printable character, with last_char on the final
// character of the message. One byte yields zero to four characters, and the
// enc port sends one character per cycle while enc_stall is low. A byte's
// characters go out while the next byte waits in the group register, and
// msg_stall holds the input while that register cannot pass its group on. The
// bit packing and pending-bit state update happen at the accept edge, which
// registers the packed group; the divide by 91 and table lookup work on that
// register, and the output sequencer registers their characters once it can
// take them, then sends them. Sending empty_message discards any unfinished
// message and emits '~'.
module base92_byte_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  output logic               msg_stall,
  input  b92_pkg::in_word_t  msg,
  output logic               enc_valid,
  input  logic               enc_stall,
  output b92_pkg::out_word_t enc
);
  import b92_pkg::*;

  group_t    grp;
  group_t    grp_next;
  logic      grp_valid;
  logic      grp_move;
  logic      msg_accept;
  logic      can_load;
  seq_load_t ld;

  assign grp_move   = grp_valid && can_load;
  assign msg_stall  = grp_valid && !grp_move;
  assign msg_accept = msg_valid && !msg_stall;

  b92_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .accept   (msg_accept),
    .word     (msg),
    .grp_next (grp_next)
  );

  always_ff @(posedge clk) begin
    if (msg_accept) begin
      grp <= grp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (msg_accept) begin
      grp_valid <= 1'b1;
    end else if (grp_move) begin
      grp_valid <= 1'b0;
    end
  end

  b92_chars u_chars (
    .grp (grp),
    .ld  (ld)
  );

  b92_out_seq u_out_seq (
    .clk       (clk),
    .rst       (rst),
    .load      (grp_move),
    .ld        (ld),
    .can_load  (can_load),
    .enc_valid (enc_valid),
    .enc_stall (enc_stall),
    .enc       (enc)
  );

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    grp_move && ld.n != 3'd0 |=> enc_valid)
    else $error("loaded characters not presented");

  a_empty_held: assert property (@(posedge clk) disable iff (rst)
    msg_accept && msg.empty_message |=> grp_valid && grp.empty)
    else $error("empty message word lost");

  a_move_frees: assert property (@(posedge clk) disable iff (rst)
    grp_move |=> !grp_valid || $past(msg_accept))
    else $error("group register held after move");

  a_range: assert property (@(posedge clk) disable iff (rst)
    grp_move |-> ld.n <= 3'd4 && (ld.n == 3'd0 || ld.ents[0].out_char >= CH_BANG))
    else $error("bad character load");
endmodule
